// ===== design/pbefd_pkg.sv =====
// Package for the packet bit-entropy flood detector.
// Holds widths, default parameters, controller codes and the control/status structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pbefd_pkg;

   localparam int WINDOW_DEF        = 16;
   localparam int MAX_PKT_BYTES_DEF = 2048;

   localparam int WORD_W     = 64;
   localparam int NBYTES_W   = 4;
   localparam int THRESH_W   = 32;
   localparam int EXCESS_W   = 40;
   localparam int ENT_W      = 24;
   localparam int FRAC_W     = 8;
   localparam int MANT_W     = 16;
   localparam int EXT_W      = 48;
   localparam int ITER_W     = 3;
   localparam logic [THRESH_W-1:0] THRESH_RESET = 32'd307200;
   localparam logic [ENT_W-1:0]    ENT_MAX      = {ENT_W{1'b1}};

   // log operand select
   typedef enum logic [1:0] {
      OP_T = 2'd0,
      OP_S = 2'd1,
      OP_D = 2'd2
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_NORM,
      ST_ITER,
      ST_MUL,
      ST_ACC,
      ST_SAVE,
      ST_SUM,
      ST_JUDGE,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic   accum;
      logic   norm;
      logic   iter;
      logic   mul;
      logic   acc;
      logic   save;
      logic   sum_add;
      logic   judge;
      logic   emit;
      logic   win_phase;
      op_type op;
   } ctrl_cmd_type;

   typedef struct packed {
      logic window_full;
      logic rsp_free;
   } ctrl_stat_type;

endpackage
`default_nettype wire

// ===== design/pbefd_if.sv =====
// Channel interfaces: packet words in, verdicts out, threshold writes.
// Depends on pbefd_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface pbefd_req_if;
   logic                          valid;
   logic                          ready;
   logic [pbefd_pkg::WORD_W-1:0]  data_word;
   logic [pbefd_pkg::NBYTES_W-1:0] word_bytes;
   logic                          last_word;
   modport source (output valid, data_word, word_bytes, last_word, input ready);
   modport sink   (input valid, data_word, word_bytes, last_word, output ready);
endinterface

interface pbefd_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            alarm_active;
   logic                            drop_mark;
   logic                            window_evaluated;
   logic signed [pbefd_pkg::EXCESS_W-1:0] entropy_excess;
   modport source (output valid, alarm_active, drop_mark, window_evaluated,
                   entropy_excess, input ready);
   modport sink   (input valid, alarm_active, drop_mark, window_evaluated,
                   entropy_excess, output ready);
endinterface

interface pbefd_csr_if;
   logic                            valid;
   logic                            ready;
   logic [pbefd_pkg::THRESH_W-1:0]  data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== design/pbefd_ctrl.sv =====
// Controller: sequences accumulation, the shared log2 unit, ring sum and verdict.
// Depends on pbefd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pbefd_ctrl #(
   parameter int WINDOW = pbefd_pkg::WINDOW_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   input  wire logic                         req_last,
   output logic                              req_ready,
   input  wire pbefd_pkg::ctrl_stat_type     stat,
   output pbefd_pkg::ctrl_cmd_type           cmd,
   output logic [$clog2(WINDOW)-1:0]         rd_addr
);
   localparam int CNT_W = $clog2(WINDOW + 1);
   localparam int IDX_W = $clog2(WINDOW);

   pbefd_pkg::state_type state_ff, state_in;
   pbefd_pkg::op_type    op_ff, op_in;
   logic                 win_ff, win_in;
   logic [pbefd_pkg::ITER_W-1:0] iter_ff, iter_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pbefd_pkg::ST_IDLE;
         op_ff    <= pbefd_pkg::OP_T;
         win_ff   <= 1'b0;
         iter_ff  <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         win_ff   <= win_in;
         iter_ff  <= iter_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign rd_addr = cnt_ff[IDX_W-1:0];

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      win_in    = win_ff;
      iter_in   = iter_ff;
      cnt_in    = cnt_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.op        = op_ff;
      cmd.win_phase = win_ff;
      unique case (state_ff)
         pbefd_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.accum = req_valid;
            if (req_valid && req_last) begin
               state_in = pbefd_pkg::ST_NORM;
               op_in    = pbefd_pkg::OP_T;
               win_in   = 1'b0;
            end
         end
         pbefd_pkg::ST_NORM: begin
            cmd.norm = 1'b1;
            iter_in  = '0;
            state_in = pbefd_pkg::ST_ITER;
         end
         pbefd_pkg::ST_ITER: begin
            cmd.iter = 1'b1;
            iter_in  = iter_ff + 1'b1;
            if (iter_ff == {pbefd_pkg::ITER_W{1'b1}}) begin
               state_in = pbefd_pkg::ST_MUL;
            end
         end
         pbefd_pkg::ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = pbefd_pkg::ST_ACC;
         end
         pbefd_pkg::ST_ACC: begin
            cmd.acc = 1'b1;
            priority if (op_ff == pbefd_pkg::OP_T) begin
               op_in    = pbefd_pkg::OP_S;
               state_in = pbefd_pkg::ST_NORM;
            end else if (op_ff == pbefd_pkg::OP_S) begin
               op_in    = pbefd_pkg::OP_D;
               state_in = pbefd_pkg::ST_NORM;
            end else if (win_ff) begin
               state_in = pbefd_pkg::ST_JUDGE;
            end else begin
               state_in = pbefd_pkg::ST_SAVE;
            end
         end
         pbefd_pkg::ST_SAVE: begin
            cmd.save = 1'b1;
            cnt_in   = '0;
            state_in = stat.window_full ? pbefd_pkg::ST_SUM : pbefd_pkg::ST_OUT;
         end
         pbefd_pkg::ST_SUM: begin
            // read data is registered and follows the address in the next cycle
            cmd.sum_add = (cnt_ff != '0);
            cnt_in      = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(WINDOW)) begin
               state_in = pbefd_pkg::ST_NORM;
               op_in    = pbefd_pkg::OP_T;
               win_in   = 1'b1;
            end
         end
         pbefd_pkg::ST_JUDGE: begin
            cmd.judge = 1'b1;
            state_in  = pbefd_pkg::ST_OUT;
         end
         pbefd_pkg::ST_OUT: begin
            if (stat.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = pbefd_pkg::ST_IDLE;
            end
         end
         default: state_in = pbefd_pkg::ST_IDLE;
      endcase
   end

endmodule
`default_nettype wire

// ===== design/pbefd_dp.sv =====
// Datapath: word popcount, log2 unit with squaring recurrence, packet ring,
// window sums, verdict and output register. Depends on pbefd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pbefd_dp #(
   parameter int WINDOW           = pbefd_pkg::WINDOW_DEF,
   parameter int MAX_PACKET_BYTES = pbefd_pkg::MAX_PKT_BYTES_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire pbefd_pkg::ctrl_cmd_type              cmd,
   output pbefd_pkg::ctrl_stat_type                  stat,
   input  wire logic [$clog2(WINDOW)-1:0]            rd_addr,
   input  wire logic [pbefd_pkg::WORD_W-1:0]         data_word,
   input  wire logic [pbefd_pkg::NBYTES_W-1:0]       word_bytes,
   input  wire logic                                 csr_valid,
   input  wire logic [pbefd_pkg::THRESH_W-1:0]       csr_data,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic                                      alarm_active,
   output logic                                      drop_mark,
   output logic                                      window_evaluated,
   output logic signed [pbefd_pkg::EXCESS_W-1:0]     entropy_excess
);
   localparam int IDX_W  = $clog2(WINDOW);
   localparam int BYTE_W = $clog2(MAX_PACKET_BYTES + 1);
   localparam int BITS_W = BYTE_W + 3;
   localparam int SUM_W  = BITS_W + $clog2(WINDOW);
   localparam int P_W    = $clog2(SUM_W);
   localparam int L_W    = P_W + pbefd_pkg::FRAC_W;
   localparam int PROD_W = SUM_W + L_W;
   localparam int ACC_W  = PROD_W + 2;
   localparam int ESUM_W = pbefd_pkg::ENT_W + $clog2(WINDOW);
   localparam int RING_W = 2 * BITS_W + pbefd_pkg::ENT_W;
   localparam int MW     = pbefd_pkg::MANT_W;
   localparam int EW     = pbefd_pkg::EXT_W;

   // ---------------- word accumulation ----------------
   logic [BITS_W-1:0] ones_ff, pkt_s_ff, pkt_t_ff;
   logic [BYTE_W-1:0] bytes_ff;
   logic [BYTE_W-1:0] room;
   logic [pbefd_pkg::NBYTES_W-1:0] n_clip, n_eff;
   logic [pbefd_pkg::WORD_W-1:0]   masked;
   logic [6:0]        word_ones;
   logic [BITS_W-1:0] ones_sum;
   logic [BYTE_W-1:0] bytes_sum;

   // clip byte count to eight and to the room left in the packet
   always_comb begin
      n_clip = (word_bytes > 4'd8) ? 4'd8 : word_bytes;
      room   = BYTE_W'(MAX_PACKET_BYTES) - bytes_ff;
      n_eff  = (room < BYTE_W'(n_clip)) ? room[pbefd_pkg::NBYTES_W-1:0] : n_clip;
      for (int i = 0; i < 8; i++) begin
         masked[8*i +: 8] = (4'(i) < n_eff) ? data_word[8*i +: 8] : 8'h00;
      end
      word_ones = 7'($countones(masked));
      ones_sum  = ones_ff + BITS_W'(word_ones);
      bytes_sum = bytes_ff + BYTE_W'(n_eff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ones_ff  <= '0;
         bytes_ff <= '0;
      end else if (cmd.accum) begin
         ones_ff  <= ones_sum;
         bytes_ff <= bytes_sum;
      end else if (cmd.norm && !cmd.win_phase && cmd.op == pbefd_pkg::OP_T) begin
         // packet closed: restart counting
         ones_ff  <= '0;
         bytes_ff <= '0;
      end
   end

   // packet totals follow the running counts until the packet closes
   always_ff @(posedge clock) begin
      if (cmd.accum) begin
         pkt_s_ff <= ones_sum;
         pkt_t_ff <= {bytes_sum, 3'b000};
      end
   end

   // ---------------- window sums ----------------
   logic [SUM_W-1:0]  sum_s_ff, sum_t_ff;
   logic [ESUM_W-1:0] sum_e_ff;
   logic [RING_W-1:0] ring [WINDOW];
   logic [RING_W-1:0] rdata_ff;
   logic [IDX_W-1:0]  slot_ff;
   logic              full_ff;

   // ---------------- log2 unit ----------------
   logic [SUM_W-1:0]  logx, x_ff;
   logic [P_W-1:0]    p_lead, p_ff;
   logic              zero_ff;
   logic [MW-1:0]     m_ff, m_norm;
   logic [MW+SUM_W-1:0] sh_wide;
   logic [pbefd_pkg::FRAC_W-1:0] frac_ff;
   logic [2*MW-1:0]   sq;
   logic [MW:0]       m_next;
   logic [L_W-1:0]    lg, lt_ff;
   logic [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic [ACC_W-2:0]  ent_pos;

   // operand select
   always_comb begin
      unique case (cmd.op)
         pbefd_pkg::OP_T: logx = cmd.win_phase ? sum_t_ff : SUM_W'(pkt_t_ff);
         pbefd_pkg::OP_S: logx = cmd.win_phase ? sum_s_ff : SUM_W'(pkt_s_ff);
         default:         logx = cmd.win_phase ? (sum_t_ff - sum_s_ff)
                                               : SUM_W'(pkt_t_ff - pkt_s_ff);
      endcase
   end

   // leading one and normalization to [2^15, 2^16)
   always_comb begin
      p_lead = '0;
      for (int i = 0; i < SUM_W; i++) begin
         if (logx[i]) p_lead = P_W'(i);
      end
      sh_wide = (MW+SUM_W)'(logx);
      if (p_lead >= P_W'(MW - 1)) begin
         sh_wide = sh_wide >> (p_lead - P_W'(MW - 1));
      end else begin
         sh_wide = sh_wide << (P_W'(MW - 1) - p_lead);
      end
      m_norm = sh_wide[MW-1:0];
   end

   // one squaring step of the fraction recurrence
   always_comb begin
      sq     = m_ff * m_ff;
      m_next = sq[2*MW-1:MW-1];
      lg     = zero_ff ? '0 : {p_ff, frac_ff};
      ent_pos = acc_ff[ACC_W-1] ? '0 : acc_ff[ACC_W-2:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.norm) begin
         x_ff    <= logx;
         p_ff    <= p_lead;
         zero_ff <= (logx == '0);
         m_ff    <= m_norm;
         frac_ff <= '0;
      end else if (cmd.iter) begin
         frac_ff <= {frac_ff[pbefd_pkg::FRAC_W-2:0], m_next[MW]};
         m_ff    <= m_next[MW] ? m_next[MW:1] : m_next[MW-1:0];
      end
      if (cmd.mul) begin
         prod_ff <= PROD_W'(x_ff) * PROD_W'(lg);
         lt_ff   <= lg;
      end
      // t*L(t) + L(t) - s*L(s) - (t-s)*L(t-s)
      if (cmd.acc) begin
         if (cmd.op == pbefd_pkg::OP_T) begin
            acc_ff <= $signed(ACC_W'(prod_ff)) + $signed(ACC_W'(lt_ff));
         end else begin
            acc_ff <= acc_ff - $signed(ACC_W'(prod_ff));
         end
      end
   end

   // ---------------- packet ring ----------------
   logic [pbefd_pkg::ENT_W-1:0] e_sat;
   assign e_sat = (ent_pos > (ACC_W-1)'(pbefd_pkg::ENT_MAX)) ? pbefd_pkg::ENT_MAX
                                                           : ent_pos[pbefd_pkg::ENT_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.save) begin
         ring[slot_ff] <= {pkt_s_ff, pkt_t_ff, e_sat};
      end
      rdata_ff <= ring[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
         full_ff <= 1'b0;
      end else if (cmd.save) begin
         if (slot_ff == IDX_W'(WINDOW - 1)) begin
            slot_ff <= '0;
            full_ff <= 1'b1;
         end else begin
            slot_ff <= slot_ff + 1'b1;
         end
      end
   end

   // running sums over the ring
   always_ff @(posedge clock) begin
      if (cmd.save) begin
         sum_s_ff <= '0;
         sum_t_ff <= '0;
         sum_e_ff <= '0;
      end else if (cmd.sum_add) begin
         sum_s_ff <= sum_s_ff + SUM_W'(rdata_ff[RING_W-1 -: BITS_W]);
         sum_t_ff <= sum_t_ff + SUM_W'(rdata_ff[pbefd_pkg::ENT_W +: BITS_W]);
         sum_e_ff <= sum_e_ff + ESUM_W'(rdata_ff[pbefd_pkg::ENT_W-1:0]);
      end
   end

   // ---------------- verdict ----------------
   logic [pbefd_pkg::THRESH_W-1:0] thresh_ff;
   logic                           alarm_ff;
   logic signed [EW-1:0]           excess_wide;
   logic signed [pbefd_pkg::EXCESS_W-1:0] excess_sat;
   logic                           over;
   logic                           st_alarm_ff, st_drop_ff, st_eval_ff;
   logic signed [pbefd_pkg::EXCESS_W-1:0] st_excess_ff;

   always_comb begin
      excess_wide = $signed(EW'(sum_e_ff)) - $signed(EW'(ent_pos));
      if (excess_wide > $signed({{(EW-pbefd_pkg::EXCESS_W+1){1'b0}},
                                 {(pbefd_pkg::EXCESS_W-1){1'b1}}})) begin
         excess_sat = {1'b0, {(pbefd_pkg::EXCESS_W-1){1'b1}}};
      end else if (excess_wide < $signed({{(EW-pbefd_pkg::EXCESS_W+1){1'b1}},
                                        {(pbefd_pkg::EXCESS_W-1){1'b0}}})) begin
         excess_sat = {1'b1, {(pbefd_pkg::EXCESS_W-1){1'b0}}};
      end else begin
         excess_sat = excess_wide[pbefd_pkg::EXCESS_W-1:0];
      end
      over = excess_sat > $signed({{(pbefd_pkg::EXCESS_W-pbefd_pkg::THRESH_W){1'b0}},
                                   thresh_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= pbefd_pkg::THRESH_RESET;
         alarm_ff  <= 1'b0;
      end else begin
         if (csr_valid) thresh_ff <= csr_data;
         if (cmd.judge) alarm_ff <= over;
      end
   end

   // staged result
   always_ff @(posedge clock) begin
      if (cmd.save) begin
         st_alarm_ff  <= alarm_ff;
         st_drop_ff   <= 1'b0;
         st_eval_ff   <= 1'b0;
         st_excess_ff <= '0;
      end else if (cmd.judge) begin
         st_alarm_ff  <= over;
         st_drop_ff   <= over && !alarm_ff;
         st_eval_ff   <= 1'b1;
         st_excess_ff <= excess_sat;
      end
   end

   // output register
   logic rsp_valid_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         alarm_active     <= st_alarm_ff;
         drop_mark        <= st_drop_ff;
         window_evaluated <= st_eval_ff;
         entropy_excess   <= st_excess_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign stat.window_full = full_ff;
   assign stat.rsp_free    = !rsp_valid_ff || rsp_ready;

endmodule
`default_nettype wire

// ===== design/packet_bit_entropy_flood_detector_top.sv =====
// Top level of the packet bit-entropy flood detector.
// Depends on pbefd_pkg, pbefd_if, pbefd_ctrl and pbefd_dp.
//
//   channel  | port    | dir | moves
//   ---------+---------+-----+-------------------------------------------
//   request  | req_ch  | in  | one item: 64-bit word, byte count, last flag
//   response | rsp_ch  | out | one item per packet: alarm, drop, excess
//   control  | csr_ch  | in  | alarm_threshold write, always ready
//
// Words are taken only in the idle state. A last word starts entropy work in the
// shared log2 unit (operands t, s, t-s: normalize, iterate, multiply, accumulate),
// then save and output; once the ring is full, ring reads, the window entropy and
// the verdict come between save and output. Synchronous active-high reset; the
// ring needs no clearing. Words are accepted while a result waits in the output
// register; none is taken from a last word until its result is emitted.
`timescale 1ns / 1ps
`default_nettype none
module packet_bit_entropy_flood_detector_top #(
   parameter int WINDOW           = pbefd_pkg::WINDOW_DEF,
   parameter int MAX_PACKET_BYTES = pbefd_pkg::MAX_PKT_BYTES_DEF
) (
   input wire logic        clock,
   input wire logic        reset,
   pbefd_req_if.sink       req_ch,
   pbefd_rsp_if.source     rsp_ch,
   pbefd_csr_if.sink       csr_ch
);
   pbefd_pkg::ctrl_cmd_type  cmd;
   pbefd_pkg::ctrl_stat_type stat;
   logic [$clog2(WINDOW)-1:0] rd_addr;
   logic req_ready;

   // controller
   pbefd_ctrl #(.WINDOW(WINDOW)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_last  (req_ch.last_word),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd),
      .rd_addr   (rd_addr)
   );

   // datapath
   pbefd_dp #(.WINDOW(WINDOW), .MAX_PACKET_BYTES(MAX_PACKET_BYTES)) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .rd_addr          (rd_addr),
      .data_word        (req_ch.data_word),
      .word_bytes       (req_ch.word_bytes),
      .csr_valid        (csr_ch.valid),
      .csr_data         (csr_ch.data),
      .rsp_valid        (rsp_ch.valid),
      .rsp_ready        (rsp_ch.ready),
      .alarm_active     (rsp_ch.alarm_active),
      .drop_mark        (rsp_ch.drop_mark),
      .window_evaluated (rsp_ch.window_evaluated),
      .entropy_excess   (rsp_ch.entropy_excess)
   );

   assign req_ch.ready = req_ready;
   assign csr_ch.ready = 1'b1;

   // a drop only comes with an evaluated window and a raised alarm
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.drop_mark |-> rsp_ch.alarm_active && rsp_ch.window_evaluated)
      else $error("drop without evaluated alarm");

   // no comparison means no excess and no drop
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.window_evaluated |->
         rsp_ch.entropy_excess == '0 && !rsp_ch.drop_mark)
      else $error("unevaluated result carries data");

   // a new result appears only after the controller emitted one
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_ch.valid) |-> $past(cmd.emit))
      else $error("result without emit");

   // words are never taken while a packet is being judged
   assert property (@(posedge clock) disable iff (reset)
      cmd.norm || cmd.iter || cmd.sum_add |-> !req_ready)
      else $error("input accepted while busy");

endmodule
`default_nettype wire

// ===== tb/packet_bit_entropy_flood_detector_top_tb.sv =====
// Testbench for the packet bit-entropy flood detector top level.
// Drives packet words and threshold writes, predicts each verdict in the bench itself.
// Depends on pbefd_pkg, pbefd_if and packet_bit_entropy_flood_detector_top.
`timescale 1ns / 1ps
module packet_bit_entropy_flood_detector_top_tb;

   localparam int WIN       = pbefd_pkg::WINDOW_DEF;
   localparam int MAX_BYTES = pbefd_pkg::MAX_PKT_BYTES_DEF;
   localparam int WDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 200;
   localparam logic signed [63:0] EXC_MAX = 64'sd549755813887;
   localparam logic signed [63:0] EXC_MIN = -64'sd549755813888;

   typedef struct packed {
      logic                                  alarm_active;
      logic                                  drop_mark;
      logic                                  window_evaluated;
      logic signed [pbefd_pkg::EXCESS_W-1:0] entropy_excess;
   } verdict_type;

   logic clock;
   logic reset;

   pbefd_req_if req_ch ();
   pbefd_rsp_if rsp_ch ();
   pbefd_csr_if csr_ch ();

   packet_bit_entropy_flood_detector_top u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Predictor state
   logic [14:0]                    pkt_ones;
   logic [11:0]                    pkt_bytes;
   logic [14:0]                    ring_ones [WIN];
   logic [14:0]                    ring_bits [WIN];
   logic [pbefd_pkg::ENT_W-1:0]    ring_ent [WIN];
   int unsigned                    slot_ptr;
   logic                           ring_full;
   logic                           alarm_on;
   logic [pbefd_pkg::THRESH_W-1:0] threshold;

   verdict_type verdict_q[$];
   int          mismatches;
   int          idle_pct;
   int          stall_pct;
   int          quiet_cycles = 0;
   logic        timed_out = 1'b0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // log2 in Q.8: leading-one position plus squaring fraction
   function automatic logic [63:0] log2_fix(input logic [63:0] x);
      int          pos;
      logic [63:0] mant;
      logic [63:0] frac;
      pos = 0;
      frac = 0;
      if (x == 0) return 0;
      for (int i = 63; i >= 0; i--)
         if (x[i]) begin
            pos = i;
            break;
         end
      mant = (pos >= 15) ? (x >> (pos - 15)) : (x << (15 - pos));
      for (int i = 0; i < 8; i++) begin
         mant = (mant * mant) >> 15;
         frac = frac << 1;
         if (mant >= 64'd65536) begin
            frac[0] = 1'b1;
            mant = mant >> 1;
         end
      end
      return 64'(pos) * 256 + frac;
   endfunction

   function automatic logic signed [63:0] bit_entropy(input logic [63:0] s,
                                                      input logic [63:0] t);
      logic signed [63:0] acc;
      if (s > t) s = t;
      acc = $signed(t * log2_fix(t)) - $signed(s * log2_fix(s))
          - $signed((t - s) * log2_fix(t - s)) + $signed(log2_fix(t));
      return (acc < 0) ? 64'sd0 : acc;
   endfunction

   task automatic clear_predictor();
      pkt_ones = 0;
      pkt_bytes = 0;
      slot_ptr = 0;
      ring_full = 1'b0;
      alarm_on = 1'b0;
      threshold = pbefd_pkg::THRESH_RESET;
   endtask

   // Update the predictor for one accepted word
   task automatic predict_word(input logic [63:0] word, input logic [3:0] nb,
                               input logic last);
      int unsigned        n;
      int unsigned        room;
      logic [63:0]        t;
      logic [63:0]        e;
      logic [63:0]        sum_s;
      logic [63:0]        sum_t;
      logic [63:0]        sum_e;
      logic signed [63:0] excess;
      verdict_type        v;
      n = (nb > 8) ? 8 : nb;
      room = (pkt_bytes < MAX_BYTES) ? MAX_BYTES - pkt_bytes : 0;
      if (n > room) n = room;
      if (n < 8) word = word & ((64'd1 << (8 * n)) - 1);
      pkt_ones = pkt_ones + 15'($countones(word));
      pkt_bytes = pkt_bytes + 12'(n);
      if (!last) return;
      t = 64'(pkt_bytes) * 8;
      e = bit_entropy(64'(pkt_ones), t);
      if (e > 64'(pbefd_pkg::ENT_MAX)) e = 64'(pbefd_pkg::ENT_MAX);
      ring_ones[slot_ptr] = pkt_ones;
      ring_bits[slot_ptr] = t[14:0];
      ring_ent[slot_ptr] = e[pbefd_pkg::ENT_W-1:0];
      pkt_ones = 0;
      pkt_bytes = 0;
      v = '0;
      if (ring_full) begin
         sum_s = 0;
         sum_t = 0;
         sum_e = 0;
         for (int i = 0; i < WIN; i++) begin
            sum_s += ring_ones[i];
            sum_t += ring_bits[i];
            sum_e += ring_ent[i];
         end
         excess = $signed(sum_e) - bit_entropy(sum_s, sum_t);
         if (excess > EXC_MAX) excess = EXC_MAX;
         if (excess < EXC_MIN) excess = EXC_MIN;
         v.window_evaluated = 1'b1;
         v.entropy_excess = excess[pbefd_pkg::EXCESS_W-1:0];
         if (excess > $signed({32'd0, threshold})) begin
            v.drop_mark = !alarm_on;
            alarm_on = 1'b1;
         end else begin
            alarm_on = 1'b0;
         end
      end
      slot_ptr = (slot_ptr + 1) % WIN;
      if (slot_ptr == 0) ring_full = 1'b1;
      v.alarm_active = alarm_on;
      verdict_q.push_back(v);
   endtask

   // Send one word, predicting at acceptance; valid drops only in idle gaps
   task automatic send_word(input logic [63:0] word, input logic [3:0] nb,
                            input logic last);
      if (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99, 0) < idle_pct) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data_word <= word;
      req_ch.word_bytes <= nb;
      req_ch.last_word <= last;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predict_word(word, nb, last);
   endtask

   task automatic send_packet(input int words, input logic [3:0] nb_fixed,
                              input int ones_bias);
      logic [63:0] w;
      logic [3:0]  nb;
      for (int i = 0; i < words; i++) begin
         case (ones_bias)
            0: w = 64'd0;
            1: w = '1;
            default: w = {$urandom, $urandom};
         endcase
         nb = (nb_fixed != 0) ? nb_fixed : 4'($urandom_range(15, 0));
         send_word(w, nb, i == words - 1);
      end
   endtask

   // Wait for all verdicts plus the block's tail latency
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (verdict_q.size() != 0 && !timed_out) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [pbefd_pkg::THRESH_W-1:0] value);
      drain();
      csr_ch.valid <= 1'b1;
      csr_ch.data <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      threshold = value;
      csr_ch.valid <= 1'b0;
   endtask

   // Directed: field extremes and special cases
   task automatic test_directed();
      send_word(64'd0, 4'd0, 1'b1);               // empty packet
      send_word('1, 4'd8, 1'b1);                  // all ones
      send_word(64'd0, 4'd8, 1'b1);               // all zeros
      send_word('1, 4'd15, 1'b1);                 // byte count above eight
      send_word(64'h8000_0000_0000_0001, 4'd1, 1'b1);
      send_word(64'hA5A5_5A5A_F00F_0FF0, 4'd0, 1'b0);
      send_word(64'h0123_4567_89AB_CDEF, 4'd5, 1'b1);
      send_word(64'h5555_5555_5555_5555, 4'd9, 1'b1);
      for (int i = 0; i < 10; i++) send_packet(1 + i % 3, 4'd0, 2);
      // oversize packet, bytes past the limit ignored
      send_packet(MAX_BYTES / 8 + 6, 4'd8, 2);
      send_packet(MAX_BYTES / 8 + 2, 4'd8, 1);
   endtask

   // Random traffic; uniform data gives low excess, skewed packets push it up
   task automatic test_random(input int items);
      int sent;
      int kind;
      int words;
      sent = 0;
      while (sent < items) begin
         kind = $urandom_range(9, 0);
         words = (kind == 0) ? $urandom_range(40, 1) : $urandom_range(6, 1);
         if (kind == 1) send_packet(words, 4'd8, 0);
         else if (kind == 2) send_packet(words, 4'd8, 1);
         else send_packet(words, 4'd0, 2);
         sent += words;
      end
   endtask

   task automatic test_thresholds();
      write_threshold(32'd0);
      test_random(100);
      write_threshold(32'hFFFF_FFFF);
      test_random(60);
      write_threshold(32'd2000);
      test_random(100);
   endtask

   task automatic test_idling();
      idle_pct = 70;
      test_random(70);
      idle_pct = 0;
      stall_pct = 70;
      test_random(70);
      idle_pct = 9;
      stall_pct = 9;
      test_random(70);
      drain();          // sender holds off until every verdict is in
      idle_pct = 0;
      stall_pct = 0;
      write_threshold(pbefd_pkg::THRESH_RESET);
      test_random(40);
   endtask

   // Result ready with random stalls
   always @(posedge clock) begin
      if (reset) rsp_ch.ready <= 1'b0;
      else rsp_ch.ready <= ($urandom_range(99, 0) >= stall_pct);
   end

   // Verdict checker
   always @(posedge clock) begin
      verdict_type got;
      verdict_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = {rsp_ch.alarm_active, rsp_ch.drop_mark, rsp_ch.window_evaluated,
                rsp_ch.entropy_excess};
         if (verdict_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected verdict %p", got);
         end else begin
            want = verdict_q.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("verdict mismatch: expected %p actual %p", want, got);
            end
         end
      end
   end

   // Watchdog on cycles without any accepted item
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (csr_ch.valid && csr_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > WDOG_LIMIT && !timed_out) begin
         timed_out = 1'b1;
         $display("packet_bit_entropy_flood_detector_top_tb NOT OK");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.data_word = '0;
      req_ch.word_bytes = '0;
      req_ch.last_word = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.data = '0;
      mismatches = 0;
      idle_pct = 0;
      stall_pct = 0;
      clear_predictor();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_thresholds();
      test_idling();
      drain();
      if (mismatches == 0 && verdict_q.size() == 0)
         $display("packet_bit_entropy_flood_detector_top_tb OK");
      else
         $display("packet_bit_entropy_flood_detector_top_tb NOT OK");
      $finish;
   end

endmodule

// ===== sim.f =====
design/pbefd_pkg.sv
design/pbefd_if.sv
design/pbefd_ctrl.sv
design/pbefd_dp.sv
design/packet_bit_entropy_flood_detector_top.sv
tb/packet_bit_entropy_flood_detector_top_tb.sv
